@@ rtl/handheld_console_memory_bus_decoder_top_macros.svh @@
// assertion macros for the memory bus decoder
// used by handheld_console_memory_bus_decoder_top, needs clk and rst in scope
`ifndef HANDHELD_CONSOLE_MEMORY_BUS_DECODER_TOP_MACROS_SVH
`define HANDHELD_CONSOLE_MEMORY_BUS_DECODER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define HCMBD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define HCMBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/hcmbd_pkg.sv @@
// shared widths, opcodes and map constants for the memory bus decoder
// no dependencies
`default_nettype none

package hcmbd_pkg;

  // transaction field widths
  localparam int OP_W   = 2;
  localparam int ADDR_W = 16;
  localparam int DATA_W = 8;

  // opcodes
  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd2;

  // rom window
  localparam int ROM_WINDOW_DEFAULT = 32768;
  localparam logic [ADDR_W-1:0] ROM_LIMIT_MAX = 16'h8000;

  // store depths
  localparam int VRAM_DEPTH = 8192;
  localparam int WRAM_DEPTH = 8192;
  localparam int OAM_DEPTH  = 160;
  localparam int IO_DEPTH   = 128;
  localparam int HRAM_DEPTH = 127;

  // map boundaries (inclusive upper ends)
  localparam logic [ADDR_W-1:0] ROM_END    = 16'h7FFF;
  localparam logic [ADDR_W-1:0] VRAM_END   = 16'h9FFF;
  localparam logic [ADDR_W-1:0] XRAM_END   = 16'hBFFF;
  localparam logic [ADDR_W-1:0] ECHO_END   = 16'hFDFF;
  localparam logic [ADDR_W-1:0] OAM_END    = 16'hFE9F;
  localparam logic [ADDR_W-1:0] UNUSED_END = 16'hFEFF;
  localparam logic [ADDR_W-1:0] IO_END     = 16'hFF7F;
  localparam logic [ADDR_W-1:0] HRAM_END   = 16'hFFFE;
  localparam logic [ADDR_W-1:0] DIV_ADDR   = 16'hFF04;

  localparam logic [DATA_W-1:0] OPEN_BUS = 8'hFF;

endpackage

`default_nettype wire

@@ rtl/hcmbd_if.sv @@
// valid/ready channel interfaces: bus command, read response, config write
// depends on hcmbd_pkg
`default_nettype none

interface hcmbd_cmd_if;
  import hcmbd_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] value;
  modport source (output valid, output op, output address, output value, input ready);
  modport sink   (input valid, input op, input address, input value, output ready);
endinterface

interface hcmbd_rsp_if;
  import hcmbd_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  modport source (output valid, output read_data, input ready);
  modport sink   (input valid, input read_data, output ready);
endinterface

interface hcmbd_cfg_if;
  import hcmbd_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] rom_limit;
  modport source (output valid, output rom_limit, input ready);
  modport sink   (input valid, input rom_limit, output ready);
endinterface

`default_nettype wire

@@ rtl/handheld_console_memory_bus_decoder_top.sv @@
// a read's byte is captured into the read stage when its command is taken, then moves
// into the output register, which drives rsp, once that register is free
// throughput: one command per cycle; a held response stalls cmd once two reads wait
// writes and rom loads give no response
// reset: synchronous; afterwards a clearing pass over every ram address zeroes the rams,
// cmd.ready stays low during it; config writes are taken at any time outside reset
`default_nettype none

`include "handheld_console_memory_bus_decoder_top_macros.svh"

module handheld_console_memory_bus_decoder_top #(
  parameter int ROM_WINDOW_BYTES = hcmbd_pkg::ROM_WINDOW_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  hcmbd_cmd_if.sink        cmd,
  hcmbd_rsp_if.source      rsp,
  hcmbd_cfg_if.sink        cfg
);
  import hcmbd_pkg::*;

  localparam int ROM_AW  = $clog2(ROM_WINDOW_BYTES);
  localparam int VRAM_AW = $clog2(VRAM_DEPTH);
  localparam int WRAM_AW = $clog2(WRAM_DEPTH);
  localparam int OAM_AW  = $clog2(OAM_DEPTH);
  localparam int IO_AW   = $clog2(IO_DEPTH);
  localparam int HRAM_AW = $clog2(HRAM_DEPTH);
  localparam logic [ADDR_W:0] ROM_WIN = (ADDR_W+1)'(ROM_WINDOW_BYTES);
  localparam logic [VRAM_AW-1:0] CLR_LAST = '1;

  // region codes
  localparam logic [2:0] RGN_ROM  = 3'd0;
  localparam logic [2:0] RGN_VRAM = 3'd1;
  localparam logic [2:0] RGN_WRAM = 3'd2;
  localparam logic [2:0] RGN_OAM  = 3'd3;
  localparam logic [2:0] RGN_IO   = 3'd4;
  localparam logic [2:0] RGN_HRAM = 3'd5;
  localparam logic [2:0] RGN_IE   = 3'd6;
  localparam logic [2:0] RGN_OPEN = 3'd7;

  // stores
  logic [DATA_W-1:0] rom_mem  [ROM_WINDOW_BYTES];
  logic [DATA_W-1:0] vram_mem [VRAM_DEPTH];
  logic [DATA_W-1:0] wram_mem [WRAM_DEPTH];
  logic [DATA_W-1:0] oam_mem  [OAM_DEPTH];
  logic [DATA_W-1:0] io_mem   [IO_DEPTH];
  logic [DATA_W-1:0] hram_mem [HRAM_DEPTH];
  logic [DATA_W-1:0] int_enable;
  logic [ADDR_W-1:0] rom_limit;

  // clearing pass
  logic               clearing;
  logic [VRAM_AW-1:0] clr_idx;

  // read stage and output register
  logic              s1_valid;
  logic [2:0]        s1_region;
  logic [DATA_W-1:0] s1_ie;
  logic [DATA_W-1:0] rom_q, vram_q, wram_q, oam_q, io_q, hram_q;
  logic              out_valid;
  logic [DATA_W-1:0] read_data;
  logic [DATA_W-1:0] read_data_next;

  logic              out_free;
  logic              s1_move;
  logic              cmd_acc;
  logic              write_en;
  logic              rom_vis;
  logic              load_in_win;
  logic [2:0]        region;

  // write port signals
  logic               vram_we, wram_we, oam_we, io_we, hram_we, rom_we;
  logic [VRAM_AW-1:0] vram_wa;
  logic [WRAM_AW-1:0] wram_wa;
  logic [OAM_AW-1:0]  oam_wa;
  logic [IO_AW-1:0]   io_wa;
  logic [HRAM_AW-1:0] hram_wa;
  logic [DATA_W-1:0]  ram_wd;
  logic [DATA_W-1:0]  io_wd;

  // handshakes
  assign out_free  = !out_valid || rsp.ready;
  assign s1_move   = s1_valid && out_free;
  assign cmd.ready = !clearing && (!s1_valid || out_free);
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign write_en  = cmd_acc && (cmd.op == OP_WRITE);
  assign cfg.ready = !rst;

  // config register, saturated to ROM_LIMIT_MAX
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_limit <= '0;
    end else if (cfg.valid) begin
      rom_limit <= (cfg.rom_limit > ROM_LIMIT_MAX) ? ROM_LIMIT_MAX : cfg.rom_limit;
    end
  end

  // address decode
  assign rom_vis     = (cmd.address < rom_limit) && ({1'b0, cmd.address} < ROM_WIN);
  assign load_in_win = {1'b0, cmd.address} < ROM_WIN;

  always_comb begin
    priority if (cmd.address <= ROM_END)    region = rom_vis ? RGN_ROM : RGN_OPEN;
    else if (cmd.address <= VRAM_END)        region = RGN_VRAM;
    else if (cmd.address <= XRAM_END)        region = RGN_OPEN;
    else if (cmd.address <= ECHO_END)        region = RGN_WRAM;
    else if (cmd.address <= OAM_END)         region = RGN_OAM;
    else if (cmd.address <= UNUSED_END)      region = RGN_OPEN;
    else if (cmd.address <= IO_END)          region = RGN_IO;
    else if (cmd.address <= HRAM_END)        region = RGN_HRAM;
    else                                     region = RGN_IE;
  end

  // clearing sweep, one entry of each ram per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == CLR_LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  // write port muxing: sweep or bus write; divider byte always stores zero
  always_comb begin
    ram_wd  = clearing ? '0 : cmd.value;
    io_wd   = (clearing || cmd.address == DIV_ADDR) ? '0 : cmd.value;
    vram_wa = clearing ? clr_idx : cmd.address[VRAM_AW-1:0];
    wram_wa = clearing ? clr_idx[WRAM_AW-1:0] : cmd.address[WRAM_AW-1:0];
    oam_wa  = clearing ? clr_idx[OAM_AW-1:0] : cmd.address[OAM_AW-1:0];
    io_wa   = clearing ? clr_idx[IO_AW-1:0] : cmd.address[IO_AW-1:0];
    hram_wa = clearing ? clr_idx[HRAM_AW-1:0] : cmd.address[HRAM_AW-1:0];
    vram_we = clearing || (write_en && region == RGN_VRAM);
    wram_we = clearing || (write_en && region == RGN_WRAM);
    oam_we  = clearing ? (clr_idx < VRAM_AW'(OAM_DEPTH)) : (write_en && region == RGN_OAM);
    io_we   = clearing ? (clr_idx < VRAM_AW'(IO_DEPTH)) : (write_en && region == RGN_IO);
    hram_we = clearing ? (clr_idx < VRAM_AW'(HRAM_DEPTH)) : (write_en && region == RGN_HRAM);
    rom_we  = cmd_acc && (cmd.op == OP_LOAD) && load_in_win;
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (vram_we) vram_mem[vram_wa] <= ram_wd;
    if (wram_we) wram_mem[wram_wa] <= ram_wd;
    if (oam_we)  oam_mem[oam_wa]   <= ram_wd;
    if (io_we)   io_mem[io_wa]     <= io_wd;
    if (hram_we) hram_mem[hram_wa] <= ram_wd;
    if (rom_we)  rom_mem[cmd.address[ROM_AW-1:0]] <= cmd.value;
  end

  // interrupt-enable byte
  always_ff @(posedge clk) begin
    if (rst) begin
      int_enable <= '0;
    end else if (write_en && region == RGN_IE) begin
      int_enable <= cmd.value;
    end
  end

  // registered memory reads, taken with every command transaction
  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      rom_q     <= rom_mem[cmd.address[ROM_AW-1:0]];
      vram_q    <= vram_mem[cmd.address[VRAM_AW-1:0]];
      wram_q    <= wram_mem[cmd.address[WRAM_AW-1:0]];
      oam_q     <= oam_mem[cmd.address[OAM_AW-1:0]];
      io_q      <= io_mem[cmd.address[IO_AW-1:0]];
      hram_q    <= hram_mem[cmd.address[HRAM_AW-1:0]];
      s1_region <= region;
      s1_ie     <= int_enable;
    end
  end

  // read stage occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_acc) begin
      s1_valid <= (cmd.op == OP_READ);
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  // response select
  always_comb begin
    unique case (s1_region)
      RGN_ROM:  read_data_next = rom_q;
      RGN_VRAM: read_data_next = vram_q;
      RGN_WRAM: read_data_next = wram_q;
      RGN_OAM:  read_data_next = oam_q;
      RGN_IO:   read_data_next = io_q;
      RGN_HRAM: read_data_next = hram_q;
      RGN_IE:   read_data_next = s1_ie;
      RGN_OPEN: read_data_next = OPEN_BUS;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      read_data <= read_data_next;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.read_data = read_data;

  // checks
  `HCMBD_ASSERT_NOW(a_no_cmd_in_clear, clearing, !cmd.ready, "command taken during clearing pass")
  `HCMBD_ASSERT_NEXT(a_read_enters, cmd_acc && cmd.op == OP_READ, s1_valid, "read lost before read stage")
  `HCMBD_ASSERT_NEXT(a_nonread_silent, cmd_acc && cmd.op != OP_READ && !s1_valid, !s1_valid, "non-read produced a response")
  `HCMBD_ASSERT_NEXT(a_s1_drains, s1_valid && !out_valid, out_valid, "read stage did not move into empty output")
  `HCMBD_ASSERT_NEXT(a_clear_ends, clearing && clr_idx == CLR_LAST, !clearing, "clearing pass overran")

endmodule

`default_nettype wire
